FILE: src/chm_pkg.sv
// chained hash map package: request and result structs, modes, status codes, fsm states
// and default sizes. no dependencies.
package chm_pkg;

  localparam int unsigned MIN_BINS_DFLT   = 8;
  localparam int unsigned MAX_BINS_DFLT   = 512;
  localparam int unsigned POOL_NODES_DFLT = 256;

  localparam int unsigned KEY_W = 32;
  localparam int unsigned VAL_W = 64;
  localparam int unsigned VIS_W = 2;

  localparam logic [1:0] MODE_STORE  = 2'd0;
  localparam logic [1:0] MODE_LOOKUP = 2'd1;
  localparam logic [1:0] MODE_REMOVE = 2'd2;
  // spare code, answered as a lookup
  localparam logic [1:0] MODE_SPARE  = 2'd3;

  typedef enum logic [1:0] {
    STATUS_DONE      = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FROZEN    = 2'd2,
    STATUS_POOL_FULL = 2'd3
  } status_e;

  typedef struct packed {
    logic [1:0]       mode;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [VIS_W-1:0] visibility;
  } req_t;

  typedef struct packed {
    logic             found;
    logic [VAL_W-1:0] old_value;
    logic [VIS_W-1:0] entry_visibility;
    logic [1:0]       status;
  } rsp_t;

  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_GROW_RD,
    ST_GROW_HEAD,
    ST_GROW_WALK,
    ST_GROW_LO,
    ST_GROW_HI,
    ST_SHR_RD,
    ST_SHR_HA,
    ST_SHR_HB,
    ST_SHR_TAIL,
    ST_SHR_CLR,
    ST_FIND,
    ST_FIND_HEAD,
    ST_FIND_WALK,
    ST_POP,
    ST_POP_DATA,
    ST_LINK,
    ST_UNLINK,
    ST_PUSH,
    ST_RESP
  } state_e;

endpackage

FILE: src/chained_hash_map.sv
// Chained hash map top level: bin head memory, node pool memory and the sequencer that walks
// chains, resizes the bin table and manages the free list. Depends on chm_pkg.
//
// After reset the block runs a clearing pass that empties every bin and chains the node pool
// into the free list; requests are held off meanwhile (the frozen register may be written at
// any time). One request is in flight at a time. A lookup reads the bin head and then walks
// its chain; a store of a new key then pops, writes and links a free node, and a remove of a
// found key unlinks the node and pushes it on the free list. Every request is paced by the
// single read port of the node memory, which walks one node per cycle. A store that doubles
// the bins first splits each old chain in two; a remove that halves them first appends each
// upper chain to the tail of the lower one. The result sits in an output register, so it may
// wait there while the next request is taken.
module chained_hash_map #(
  parameter int unsigned MIN_BINS   = chm_pkg::MIN_BINS_DFLT,
  parameter int unsigned MAX_BINS   = chm_pkg::MAX_BINS_DFLT,
  parameter int unsigned POOL_NODES = chm_pkg::POOL_NODES_DFLT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  chm_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output chm_pkg::rsp_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);
  import chm_pkg::*;

  localparam int unsigned NW       = $clog2(POOL_NODES + 1);
  localparam int unsigned AW       = $clog2(POOL_NODES);
  localparam int unsigned BW       = $clog2(MAX_BINS);
  localparam int unsigned CW       = $clog2(MAX_BINS + 1);
  localparam int unsigned INIT_LEN = (MAX_BINS > POOL_NODES) ? MAX_BINS : POOL_NODES;
  localparam int unsigned IW       = $clog2(INIT_LEN);
  localparam int unsigned MW       = $clog2(MAX_BINS + POOL_NODES + 1) + 4;
  localparam logic [NW-1:0] NIL    = NW'(POOL_NODES);

  typedef struct packed {
    logic [NW-1:0]    nxt;
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
    logic [VIS_W-1:0] vis;
  } node_t;

  // memories
  logic [NW-1:0] bin_mem  [MAX_BINS];
  node_t         node_mem [POOL_NODES];

  logic [BW-1:0] bin_ra, bin_wa;
  logic [NW-1:0] bin_wd, bin_rd_q;
  logic          bin_we;
  logic [NW-1:0] node_ra, node_wa;
  node_t         node_wd, node_rd_q;
  logic          node_we_next, node_we_data;

  always_ff @(posedge clk_i) begin
    if (bin_we) begin
      bin_mem[bin_wa] <= bin_wd;
    end
    bin_rd_q <= bin_mem[bin_ra];
  end

  always_ff @(posedge clk_i) begin
    if (node_we_next) begin
      node_mem[node_wa[AW-1:0]].nxt <= node_wd.nxt;
    end
    if (node_we_data) begin
      node_mem[node_wa[AW-1:0]].key   <= node_wd.key;
      node_mem[node_wa[AW-1:0]].value <= node_wd.value;
      node_mem[node_wa[AW-1:0]].vis   <= node_wd.vis;
    end
    node_rd_q <= node_mem[node_ra[AW-1:0]];
  end

  // registers
  state_e        state_q, state_d;
  logic [IW-1:0] sweep_q, sweep_d;
  req_t          req_q, req_d;
  logic          frozen_q;
  logic [CW-1:0] bins_q, bins_d;
  logic [NW-1:0] count_q, count_d;
  logic [NW-1:0] free_q, free_d;
  logic [BW-1:0] idx_q, idx_d;
  logic [NW-1:0] lo_head_q, lo_head_d, lo_tail_q, lo_tail_d;
  logic [NW-1:0] hi_head_q, hi_head_d, hi_tail_q, hi_tail_d;
  logic [NW-1:0] cur_q, cur_d, prev_q, prev_d, cur_nxt_q, cur_nxt_d;
  rsp_t          res_q, res_d, out_q, out_d;
  logic          out_valid_q, out_valid_d;

  // shared conditions
  logic          is_store, is_remove, refused, grow_ok, shrink_ok;
  logic          q_store, q_remove, rd_hit, rd_last, grow_hi, grow_last, shr_last;
  logic          out_free, walk_miss, walk_hit, pool_ok;
  logic [BW-1:0] bin_mask, req_bin, half_b;

  assign is_store  = (in_data_i.mode == MODE_STORE);
  assign is_remove = (in_data_i.mode == MODE_REMOVE);
  assign refused   = (is_store || is_remove) && frozen_q;
  assign grow_ok   = ((MW'(count_q) << 2) >= MW'(bins_q) * MW'(3))
                     && ((MW'(bins_q) << 1) <= MW'(MAX_BINS));
  assign shrink_ok = (MW'(count_q) * MW'(10) < MW'(bins_q) * MW'(3))
                     && (MW'(bins_q >> 1) >= MW'(MIN_BINS));

  assign q_store   = (req_q.mode == MODE_STORE);
  assign q_remove  = (req_q.mode == MODE_REMOVE);
  assign bin_mask  = BW'(bins_q - CW'(1));
  assign req_bin   = req_q.key[BW-1:0] & bin_mask;
  assign half_b    = BW'(bins_q >> 1);
  assign rd_hit    = (node_rd_q.key == req_q.key);
  assign rd_last   = (node_rd_q.nxt == NIL);
  // during doubling the old bin count is the bit that splits each chain
  assign grow_hi   = |(node_rd_q.key[BW-1:0] & BW'(bins_q));
  assign grow_last = (idx_q == bin_mask);
  assign shr_last  = (idx_q == half_b - BW'(1));
  assign out_free  = !out_valid_q || !out_stall_i;
  assign pool_ok   = (free_q != NIL);
  assign walk_miss = ((state_q == ST_FIND_HEAD) && (bin_rd_q == NIL))
                     || ((state_q == ST_FIND_WALK) && !rd_hit && rd_last);
  assign walk_hit  = (state_q == ST_FIND_WALK) && rd_hit;

  assign in_stall_o  = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (sweep_q == IW'(INIT_LEN - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          priority if (refused)                state_d = ST_RESP;
          else if (is_store && grow_ok)        state_d = ST_GROW_RD;
          else if (is_remove && shrink_ok)     state_d = ST_SHR_RD;
          else                                 state_d = ST_FIND;
        end
      end
      ST_GROW_RD:   state_d = ST_GROW_HEAD;
      ST_GROW_HEAD: state_d = (bin_rd_q == NIL) ? ST_GROW_LO : ST_GROW_WALK;
      ST_GROW_WALK: begin
        if (rd_last) state_d = ST_GROW_LO;
      end
      ST_GROW_LO:   state_d = ST_GROW_HI;
      ST_GROW_HI:   state_d = grow_last ? ST_FIND : ST_GROW_RD;
      ST_SHR_RD:    state_d = ST_SHR_HA;
      ST_SHR_HA:    state_d = ST_SHR_HB;
      ST_SHR_HB:    state_d = (lo_head_q == NIL) ? ST_SHR_CLR : ST_SHR_TAIL;
      ST_SHR_TAIL: begin
        if (rd_last) state_d = ST_SHR_CLR;
      end
      ST_SHR_CLR:   state_d = shr_last ? ST_FIND : ST_SHR_RD;
      ST_FIND:      state_d = ST_FIND_HEAD;
      ST_FIND_HEAD, ST_FIND_WALK: begin
        priority if (walk_hit)  state_d = q_remove ? ST_UNLINK : ST_RESP;
        else if (walk_miss)     state_d = (q_store && pool_ok) ? ST_POP : ST_RESP;
        else                    state_d = ST_FIND_WALK;
      end
      ST_POP:       state_d = ST_POP_DATA;
      ST_POP_DATA:  state_d = ST_LINK;
      ST_LINK:      state_d = ST_RESP;
      ST_UNLINK:    state_d = ST_PUSH;
      ST_PUSH:      state_d = ST_RESP;
      ST_RESP: begin
        if (out_free) state_d = ST_IDLE;
      end
      default:      state_d = ST_INIT;
    endcase
  end

  // datapath and memory controls
  always_comb begin
    sweep_d      = sweep_q;
    req_d        = req_q;
    bins_d       = bins_q;
    count_d      = count_q;
    free_d       = free_q;
    idx_d        = idx_q;
    lo_head_d    = lo_head_q;
    lo_tail_d    = lo_tail_q;
    hi_head_d    = hi_head_q;
    hi_tail_d    = hi_tail_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    cur_nxt_d    = cur_nxt_q;
    res_d        = res_q;
    out_d        = out_q;
    out_valid_d  = out_valid_q && out_stall_i;
    bin_ra       = idx_q;
    bin_we       = 1'b0;
    bin_wa       = idx_q;
    bin_wd       = NIL;
    node_ra      = cur_q;
    node_we_next = 1'b0;
    node_we_data = 1'b0;
    node_wa      = cur_q;
    node_wd      = node_rd_q;

    unique case (state_q)
      ST_INIT: begin
        sweep_d = sweep_q + IW'(1);
        if (MW'(sweep_q) < MW'(MAX_BINS)) begin
          bin_we = 1'b1;
          bin_wa = BW'(sweep_q);
          bin_wd = NIL;
        end
        if (MW'(sweep_q) < MW'(POOL_NODES)) begin
          node_we_next = 1'b1;
          node_wa      = NW'(sweep_q);
          node_wd.nxt  = NW'(MW'(sweep_q) + MW'(1));
        end
      end
      ST_IDLE: begin
        if (in_valid_i) begin
          req_d = in_data_i;
          res_d = '0;
          idx_d = '0;
          if (refused) res_d.status = STATUS_FROZEN;
        end
      end
      ST_GROW_RD: begin
        bin_ra = idx_q;
      end
      ST_GROW_HEAD: begin
        lo_head_d = NIL;
        lo_tail_d = NIL;
        hi_head_d = NIL;
        hi_tail_d = NIL;
        node_ra   = bin_rd_q;
        cur_d     = bin_rd_q;
      end
      ST_GROW_WALK: begin
        // append the node to the tail of its new chain
        if (grow_hi) begin
          if (hi_tail_q == NIL) begin
            hi_head_d = cur_q;
          end else begin
            node_we_next = 1'b1;
            node_wa      = hi_tail_q;
            node_wd.nxt  = cur_q;
          end
          hi_tail_d = cur_q;
        end else begin
          if (lo_tail_q == NIL) begin
            lo_head_d = cur_q;
          end else begin
            node_we_next = 1'b1;
            node_wa      = lo_tail_q;
            node_wd.nxt  = cur_q;
          end
          lo_tail_d = cur_q;
        end
        node_ra = node_rd_q.nxt;
        cur_d   = node_rd_q.nxt;
      end
      ST_GROW_LO: begin
        bin_we = 1'b1;
        bin_wa = idx_q;
        bin_wd = lo_head_q;
        if (lo_tail_q != NIL) begin
          node_we_next = 1'b1;
          node_wa      = lo_tail_q;
          node_wd.nxt  = NIL;
        end
      end
      ST_GROW_HI: begin
        bin_we = 1'b1;
        bin_wa = idx_q + BW'(bins_q);
        bin_wd = hi_head_q;
        if (hi_tail_q != NIL) begin
          node_we_next = 1'b1;
          node_wa      = hi_tail_q;
          node_wd.nxt  = NIL;
        end
        if (grow_last) bins_d = bins_q << 1;
        else           idx_d  = idx_q + BW'(1);
      end
      ST_SHR_RD: begin
        bin_ra = idx_q;
      end
      ST_SHR_HA: begin
        lo_head_d = bin_rd_q;
        bin_ra    = idx_q + half_b;
      end
      ST_SHR_HB: begin
        hi_head_d = bin_rd_q;
        if (lo_head_q == NIL) begin
          bin_we = 1'b1;
          bin_wa = idx_q;
          bin_wd = bin_rd_q;
        end
        node_ra = lo_head_q;
        cur_d   = lo_head_q;
      end
      ST_SHR_TAIL: begin
        // the upper chain follows the tail of the lower one
        if (rd_last) begin
          node_we_next = 1'b1;
          node_wa      = cur_q;
          node_wd.nxt  = hi_head_q;
        end else begin
          node_ra = node_rd_q.nxt;
          cur_d   = node_rd_q.nxt;
        end
      end
      ST_SHR_CLR: begin
        bin_we = 1'b1;
        bin_wa = idx_q + half_b;
        bin_wd = NIL;
        if (shr_last) bins_d = bins_q >> 1;
        else          idx_d  = idx_q + BW'(1);
      end
      ST_FIND: begin
        bin_ra = req_bin;
        prev_d = NIL;
      end
      ST_FIND_HEAD, ST_FIND_WALK: begin
        if (walk_hit) begin
          res_d.found            = 1'b1;
          res_d.old_value        = node_rd_q.value;
          res_d.entry_visibility = node_rd_q.vis;
          res_d.status           = STATUS_DONE;
          cur_nxt_d              = node_rd_q.nxt;
          if (q_store) begin
            node_we_data  = 1'b1;
            node_wa       = cur_q;
            node_wd.value = req_q.value;
          end
        end else if (walk_miss) begin
          if (state_q == ST_FIND_WALK) prev_d = cur_q;
          if (!q_store)      res_d.status = STATUS_NOT_FOUND;
          else if (!pool_ok) res_d.status = STATUS_POOL_FULL;
          else               res_d.status = STATUS_DONE;
        end else begin
          if (state_q == ST_FIND_WALK) begin
            prev_d  = cur_q;
            node_ra = node_rd_q.nxt;
            cur_d   = node_rd_q.nxt;
          end else begin
            node_ra = bin_rd_q;
            cur_d   = bin_rd_q;
          end
        end
      end
      ST_POP: begin
        node_ra = free_q;
      end
      ST_POP_DATA: begin
        free_d        = node_rd_q.nxt;
        cur_d         = free_q;
        node_we_next  = 1'b1;
        node_we_data  = 1'b1;
        node_wa       = free_q;
        node_wd.nxt   = NIL;
        node_wd.key   = req_q.key;
        node_wd.value = req_q.value;
        node_wd.vis   = req_q.visibility;
      end
      ST_LINK: begin
        count_d = count_q + NW'(1);
        if (prev_q == NIL) begin
          bin_we = 1'b1;
          bin_wa = req_bin;
          bin_wd = cur_q;
        end else begin
          node_we_next = 1'b1;
          node_wa      = prev_q;
          node_wd.nxt  = cur_q;
        end
      end
      ST_UNLINK: begin
        if (prev_q == NIL) begin
          bin_we = 1'b1;
          bin_wa = req_bin;
          bin_wd = cur_nxt_q;
        end else begin
          node_we_next = 1'b1;
          node_wa      = prev_q;
          node_wd.nxt  = cur_nxt_q;
        end
      end
      ST_PUSH: begin
        node_we_next = 1'b1;
        node_wa      = cur_q;
        node_wd.nxt  = free_q;
        free_d       = cur_q;
        if (count_q != '0) count_d = count_q - NW'(1);
      end
      ST_RESP: begin
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      sweep_q     <= '0;
      frozen_q    <= 1'b0;
      bins_q      <= CW'(MIN_BINS);
      count_q     <= '0;
      free_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sweep_q     <= sweep_d;
      bins_q      <= bins_d;
      count_q     <= count_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) frozen_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q     <= req_d;
    idx_q     <= idx_d;
    lo_head_q <= lo_head_d;
    lo_tail_q <= lo_tail_d;
    hi_head_q <= hi_head_d;
    hi_tail_q <= hi_tail_d;
    cur_q     <= cur_d;
    prev_q    <= prev_d;
    cur_nxt_q <= cur_nxt_d;
    res_q     <= res_d;
    out_q     <= out_d;
  end

  // checks
  a_bins_pow2: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(bins_q))
    else $error("bin count not a power of two");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    MW'(count_q) <= MW'(POOL_NODES))
    else $error("entry count beyond pool size");

  a_out_from_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESP))
    else $error("result loaded outside response state");

  a_grow_doubles: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GROW_HI && grow_last) |=> (bins_q == ($past(bins_q) << 1)))
    else $error("grow did not double the bins");

  a_no_dual_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_GROW_WALK && !rd_last) |-> (node_ra != node_wa || !node_we_next))
    else $error("chain walk reads the node it relinks");

endmodule

FILE: dv/chained_hash_map_tb.sv
// self-checking testbench for chained_hash_map: directed and random store, lookup and remove
// requests checked against an in-bench model of the bins, chains and free pool. depends on chm_pkg.
module chained_hash_map_tb;
  import chm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBINS_MIN = MIN_BINS_DFLT;
  localparam int unsigned NBINS_MAX = MAX_BINS_DFLT;
  localparam int unsigned NPOOL     = POOL_NODES_DFLT;
  localparam int unsigned NIL       = NPOOL;
  localparam int unsigned KEYSET    = 300;
  localparam longint unsigned CYCLE_LIMIT = 3000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  rsp_t out_data;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_data = 1'b0;

  chained_hash_map u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk = ~clk;

  // map model state
  int unsigned bin_head [NBINS_MAX];
  logic [KEY_W-1:0] nd_key [NPOOL];
  logic [VAL_W-1:0] nd_val [NPOOL];
  logic [VIS_W-1:0] nd_vis [NPOOL];
  int unsigned nd_next [NPOOL];
  int unsigned free_top, n_entries, n_bins;
  bit is_frozen;

  req_t pending_q[$];
  rsp_t expected_q[$];
  logic [KEY_W-1:0] key_set [KEYSET];
  int unsigned errors = 0;
  longint unsigned cycles = 0;
  int unsigned send_gap = 0, recv_gap = 0, hold_cnt = 0;
  bit long_hold_req = 0;
  bit no_idle = 0;

  function automatic int unsigned bin_sel(logic [KEY_W-1:0] k, int unsigned nb);
    return k & (nb - 1);
  endfunction

  function automatic void rebin(int unsigned nb);
    int unsigned hd [NBINS_MAX];
    int unsigned tl [NBINS_MAX];
    int unsigned n, nx, b;
    for (int i = 0; i < NBINS_MAX; i++) begin
      hd[i] = NIL;
      tl[i] = NIL;
    end
    for (int i = 0; i < n_bins; i++) begin
      n = bin_head[i];
      while (n < NIL) begin
        nx = nd_next[n];
        nd_next[n] = NIL;
        b = bin_sel(nd_key[n], nb);
        if (tl[b] < NIL) nd_next[tl[b]] = n;
        else hd[b] = n;
        tl[b] = n;
        n = nx;
      end
    end
    bin_head = hd;
    n_bins = nb;
  endfunction

  function automatic int unsigned chain_find(logic [KEY_W-1:0] k, output int unsigned prv);
    int unsigned n;
    n = bin_head[bin_sel(k, n_bins)];
    prv = NIL;
    while (n < NIL && nd_key[n] != k) begin
      prv = n;
      n = nd_next[n];
    end
    return n;
  endfunction

  function automatic rsp_t map_apply(req_t r);
    rsp_t o;
    int unsigned n, prv;
    o = '0;
    if ((r.mode == MODE_STORE || r.mode == MODE_REMOVE) && is_frozen) begin
      o.status = STATUS_FROZEN;
      return o;
    end
    if (r.mode == MODE_STORE) begin
      if (4 * n_entries >= 3 * n_bins && 2 * n_bins <= NBINS_MAX) rebin(2 * n_bins);
      n = chain_find(r.key, prv);
      if (n < NIL) begin
        o.found = 1'b1;
        o.old_value = nd_val[n];
        o.entry_visibility = nd_vis[n];
        nd_val[n] = r.value;
        return o;
      end
      if (free_top >= NIL) begin
        o.status = STATUS_POOL_FULL;
        return o;
      end
      n = free_top;
      free_top = nd_next[n];
      nd_key[n] = r.key;
      nd_val[n] = r.value;
      nd_vis[n] = r.visibility;
      nd_next[n] = NIL;
      if (prv < NIL) nd_next[prv] = n;
      else bin_head[bin_sel(r.key, n_bins)] = n;
      n_entries++;
      o.status = STATUS_DONE;
      return o;
    end
    if (r.mode == MODE_REMOVE) begin
      if (10 * n_entries < 3 * n_bins && (n_bins >> 1) >= NBINS_MIN) rebin(n_bins >> 1);
      n = chain_find(r.key, prv);
      if (n >= NIL) begin
        o.status = STATUS_NOT_FOUND;
        return o;
      end
      o.found = 1'b1;
      o.old_value = nd_val[n];
      o.entry_visibility = nd_vis[n];
      if (prv < NIL) nd_next[prv] = nd_next[n];
      else bin_head[bin_sel(r.key, n_bins)] = nd_next[n];
      nd_next[n] = free_top;
      free_top = n;
      if (n_entries > 0) n_entries--;
      return o;
    end
    // lookup, and the unused mode behaves the same
    n = chain_find(r.key, prv);
    if (n >= NIL) begin
      o.status = STATUS_NOT_FOUND;
      return o;
    end
    o.found = 1'b1;
    o.old_value = nd_val[n];
    o.entry_visibility = nd_vis[n];
    return o;
  endfunction

  task automatic report(string what, logic [VAL_W-1:0] got, logic [VAL_W-1:0] want);
    errors++;
    $display("mismatch %s: got %h want %h", what, got, want);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // request driver
  always @(posedge clk) begin
    logic nxt_valid;
    nxt_valid = in_valid;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_q.push_back(map_apply(in_data));
        nxt_valid = 1'b0;
        send_gap = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (!nxt_valid) begin
        if (send_gap > 0) send_gap--;
        else if (pending_q.size() > 0) begin
          in_data <= pending_q.pop_front();
          nxt_valid = 1'b1;
        end
      end
      in_valid <= nxt_valid;
    end
  end

  // result monitor
  always @(posedge clk) begin
    rsp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) report("unexpected result", out_data.old_value, '0);
        else begin
          want = expected_q.pop_front();
          if (out_data.found !== want.found)
            report("found", VAL_W'(out_data.found), VAL_W'(want.found));
          if (out_data.old_value !== want.old_value)
            report("old_value", out_data.old_value, want.old_value);
          if (out_data.entry_visibility !== want.entry_visibility)
            report("visibility", VAL_W'(out_data.entry_visibility),
                   VAL_W'(want.entry_visibility));
          if (out_data.status !== want.status)
            report("status", VAL_W'(out_data.status), VAL_W'(want.status));
        end
        recv_gap = no_idle ? 0 : $urandom_range(0, 11);
      end
      if (long_hold_req) begin
        hold_cnt = 400;
        long_hold_req = 0;
      end
      if (hold_cnt > 0) begin
        hold_cnt--;
        out_stall <= 1'b1;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic add_req(logic [1:0] m, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                         logic [VIS_W-1:0] vis);
    req_t r;
    r.mode = m;
    r.key = k;
    r.value = v;
    r.visibility = vis;
    pending_q.push_back(r);
  endtask

  function automatic logic [VAL_W-1:0] rand_val();
    return {$urandom, $urandom};
  endfunction

  task automatic drain();
    while (pending_q.size() > 0 || in_valid || expected_q.size() > 0) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_frozen(bit f);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= f;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    is_frozen = f;
    cfg_valid <= 1'b0;
  endtask

  task automatic random_mix(int unsigned count, int unsigned store_pct, int unsigned rem_pct,
                            int unsigned span);
    int unsigned p;
    for (int i = 0; i < count; i++) begin
      p = $urandom_range(0, 99);
      if (p < store_pct)
        add_req(MODE_STORE, key_set[$urandom_range(0, span - 1)], rand_val(),
                VIS_W'($urandom));
      else if (p < store_pct + rem_pct)
        add_req(MODE_REMOVE, key_set[$urandom_range(0, span - 1)], rand_val(),
                VIS_W'($urandom));
      else
        add_req($urandom_range(0, 1) ? MODE_LOOKUP : MODE_SPARE,
                key_set[$urandom_range(0, span - 1)], rand_val(), VIS_W'($urandom));
    end
  endtask

  initial begin
    for (int i = 0; i < NBINS_MAX; i++) bin_head[i] = NIL;
    for (int i = 0; i < NPOOL; i++) begin
      nd_key[i] = '0;
      nd_val[i] = '0;
      nd_vis[i] = '0;
      nd_next[i] = i + 1;
    end
    free_top = 0;
    n_entries = 0;
    n_bins = NBINS_MIN;
    is_frozen = 0;
    key_set[0] = '0;
    key_set[1] = '1;
    for (int i = 2; i < KEYSET; i++) key_set[i] = $urandom;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_frozen(1'b0);

    // directed: extremes, shared bin chains, update, head and middle unlink
    add_req(MODE_STORE, 32'h0, 64'h0, 2'd0);
    add_req(MODE_STORE, 32'hffff_ffff, 64'hffff_ffff_ffff_ffff, 2'd3);
    add_req(MODE_STORE, 32'h8, 64'h5555_aaaa_5555_aaaa, 2'd1);
    add_req(MODE_STORE, 32'h10, 64'haaaa_5555_aaaa_5555, 2'd2);
    add_req(MODE_LOOKUP, 32'h0, '1, 2'd3);
    add_req(MODE_LOOKUP, 32'h8, '0, 2'd0);
    add_req(MODE_LOOKUP, 32'h10, '0, 2'd0);
    add_req(MODE_LOOKUP, 32'hffff_ffff, '0, 2'd0);
    add_req(MODE_LOOKUP, 32'h18, '0, 2'd0);
    add_req(MODE_SPARE, 32'h8, '0, 2'd0);
    add_req(MODE_STORE, 32'h8, 64'h0123_4567_89ab_cdef, 2'd3);
    add_req(MODE_REMOVE, 32'h8, '0, 2'd0);
    add_req(MODE_REMOVE, 32'h8, '0, 2'd0);
    add_req(MODE_REMOVE, 32'h0, '0, 2'd0);
    add_req(MODE_LOOKUP, 32'h10, '0, 2'd0);
    add_req(MODE_REMOVE, 32'h7fff_fff0, '1, 2'd3);
    drain();

    // frozen refuses store and remove but lookup still answers
    write_frozen(1'b1);
    add_req(MODE_STORE, 32'h20, rand_val(), 2'd1);
    add_req(MODE_REMOVE, 32'h10, '0, 2'd0);
    add_req(MODE_LOOKUP, 32'h10, '0, 2'd0);
    add_req(MODE_LOOKUP, 32'h20, '0, 2'd0);
    drain();
    write_frozen(1'b0);

    // store-heavy mix grows the bins; long output hold backs up the input
    long_hold_req = 1;
    random_mix(300, 55, 15, 150);
    drain();

    // remove-heavy mix shrinks them again
    no_idle = 1;
    random_mix(150, 10, 60, 150);
    drain();
    no_idle = 0;
    random_mix(150, 10, 60, 150);
    drain();

    // fill the pool past its end, then empty it
    for (int i = 0; i < KEYSET; i++)
      add_req(MODE_STORE, key_set[i], rand_val(), VIS_W'($urandom));
    random_mix(40, 20, 0, KEYSET);
    for (int i = 0; i < KEYSET; i++) add_req(MODE_REMOVE, key_set[i], '0, 2'd0);
    drain();

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
